[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks an implication whose consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lphm_pkg.sv]
package lphm_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KIND_W          = 2;
    localparam int WORD_W          = 64;
    localparam int LIM_W           = 10;
    localparam int SLOT_W          = 10;
    localparam int TAG_W           = 2;
    localparam int HSTEP_W         = 3;

    localparam logic [LIM_W-1:0]   LOAD_LIMIT_RESET = 10'd716;
    localparam logic [HSTEP_W-1:0] HASH_STEPS       = 3'd7;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_EVAL,
        ST_ACT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic hash_step;
        logic probe_start;
        logic eval;
        logic act;
        logic resp;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic probe_end;
        logic out_free;
    } t_stat;

    // One round of the 64-bit integer mix; right shifts are arithmetic.
    function automatic logic [WORD_W-1:0] wang_step(input logic [WORD_W-1:0] n,
                                                    input logic [HSTEP_W-1:0] step);
        logic [WORD_W-1:0] r;
        unique case (step)
            3'd0:    r = (~n) + (n << 21);
            3'd1:    r = n ^ WORD_W'($signed(n) >>> 24);
            3'd2:    r = n + (n << 3) + (n << 8);
            3'd3:    r = n ^ WORD_W'($signed(n) >>> 14);
            3'd4:    r = n + (n << 2) + (n << 4);
            3'd5:    r = n ^ WORD_W'($signed(n) >>> 28);
            3'd6:    r = n + (n << 31);
            default: r = n;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/linear_probe_hash_map.sv]
// Channel    Direction  Handshake          Payload
// request    in         i_valid / o_ready  i_kind, i_key, i_value
// response   out        o_valid / i_ready  o_found, o_read_value, o_status, o_slot_index
// config     in         i_cfg_we           i_cfg_data (load limit)
//
// After acceptance a transaction runs the seven-round key hash, then probes
// slots one after another; each probe waits for the registered read of the slot
// memories, and the response is loaded once the probe ends.
// After reset the block sweeps the tag memory before it accepts a request;
// configuration writes are taken during the sweep.
// A response waits in the output register while the next request is hashed.

module linear_probe_hash_map #(
    parameter int TABLE_DEPTH = lphm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lphm_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [lphm_pkg::WORD_W-1:0]  i_key,
    input  logic signed [lphm_pkg::WORD_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_found,
    output logic signed [lphm_pkg::WORD_W-1:0]  o_read_value,
    output logic                                o_status,
    output logic [lphm_pkg::SLOT_W-1:0]         o_slot_index,
    input  logic                                i_cfg_we,
    input  logic [lphm_pkg::LIM_W-1:0]          i_cfg_data
);
    import lphm_pkg::*;

    // Commands flow from the controller to the datapath, and status flows back.
    t_cmd  cmd;
    t_stat stat;

    // The controller sequences clear, hash, probe, update and response steps.
    lphm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath holds the slot memories, counts, hash and output register.
    lphm_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

    // Requests are taken only when the controller is waiting for one.
    assign o_ready = cmd.in_ready;

endmodule

[hw/rtl/lphm_ram.sv]
module lphm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lphm_ctrl.sv]
module lphm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lphm_pkg::t_stat i_stat,
    output lphm_pkg::t_cmd  o_cmd
);
    import lphm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_valid) n_state = ST_HASH;
            ST_HASH:  if (i_stat.hash_done) n_state = ST_READ;
            ST_READ:  n_state = ST_EVAL;
            ST_EVAL:  n_state = i_stat.probe_end ? ST_ACT : ST_READ;
            ST_ACT:   n_state = ST_RESP;
            ST_RESP:  if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_valid;
            end
            ST_HASH: begin
                o_cmd.hash_step   = !i_stat.hash_done;
                o_cmd.probe_start = i_stat.hash_done;
            end
            ST_READ:  o_cmd = '0;
            ST_EVAL:  o_cmd.eval = 1'b1;
            ST_ACT:   o_cmd.act = 1'b1;
            ST_RESP:  o_cmd.resp = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

[hw/rtl/lphm_dp.sv]
module lphm_dp #(
    parameter int TABLE_DEPTH = lphm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lphm_pkg::t_cmd                      i_cmd,
    output lphm_pkg::t_stat                     o_stat,
    input  logic [lphm_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [lphm_pkg::WORD_W-1:0]  i_key,
    input  logic signed [lphm_pkg::WORD_W-1:0]  i_value,
    input  logic                                i_cfg_we,
    input  logic [lphm_pkg::LIM_W-1:0]          i_cfg_data,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic                                o_found,
    output logic signed [lphm_pkg::WORD_W-1:0]  o_read_value,
    output logic                                o_status,
    output logic [lphm_pkg::SLOT_W-1:0]         o_slot_index
);
    import lphm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W + 1 > LIM_W) ? CNT_W + 1 : LIM_W;

    logic [KIND_W-1:0]  r_kind;
    logic [WORD_W-1:0]  r_key;
    logic [WORD_W-1:0]  r_val;
    logic [WORD_W-1:0]  r_hash;
    logic [HSTEP_W-1:0] r_hstep;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_pcnt;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_at;
    logic [WORD_W-1:0]  r_hit_val;
    logic               r_tomb_seen;
    logic [IDX_W-1:0]   r_tomb_at;
    logic               r_empty_seen;
    logic [IDX_W-1:0]   r_empty_at;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_tomb;
    logic [LIM_W-1:0]   r_limit;
    logic [IDX_W-1:0]   r_clr;

    logic               r_res_found;
    logic [WORD_W-1:0]  r_res_val;
    logic               r_res_status;
    logic [SLOT_W-1:0]  r_res_slot;

    logic               r_ov;
    logic               r_o_found;
    logic [WORD_W-1:0]  r_o_val;
    logic               r_o_status;
    logic [SLOT_W-1:0]  r_o_slot;

    logic [TAG_W-1:0]   tag_q;
    logic [WORD_W-1:0]  key_q;
    logic [WORD_W-1:0]  val_q;

    logic               tag_we;
    logic [IDX_W-1:0]   tag_waddr;
    logic [TAG_W-1:0]   tag_wdata;
    logic               key_we;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;
    logic [WORD_W-1:0]  val_wdata;

    logic               w_is_empty;
    logic               w_is_hit;
    logic               w_is_tomb;
    logic               w_last;
    logic               w_is_lookup;
    logic               w_is_insert;
    logic               w_is_remove;
    logic               w_full;
    logic               w_ins_new;
    logic [IDX_W-1:0]   w_ins_at;

    lphm_ram #(.WIDTH(TAG_W), .DEPTH(TABLE_DEPTH)) u_tag_ram (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(tag_wdata),
        .i_raddr(r_idx), .o_rdata(tag_q)
    );

    lphm_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(w_ins_at), .i_wdata(r_key),
        .i_raddr(r_idx), .o_rdata(key_q)
    );

    lphm_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_raddr(r_idx), .o_rdata(val_q)
    );

    // Slot classification for the entry read in the previous cycle.
    assign w_is_empty = (tag_q == TAG_EMPTY);
    assign w_is_hit   = (tag_q == TAG_USED) && (key_q == r_key);
    assign w_is_tomb  = (tag_q == TAG_TOMB);
    assign w_last     = (r_pcnt == CNT_W'(TABLE_DEPTH - 1));

    assign w_is_lookup = (r_kind == KIND_LOOKUP);
    assign w_is_insert = (r_kind == KIND_INSERT);
    assign w_is_remove = (r_kind == KIND_REMOVE);

    assign w_full    = (CMP_W'(r_used) + CMP_W'(r_tomb)) > CMP_W'(r_limit);
    assign w_ins_new = w_is_insert && !r_hit && !w_full && (r_tomb_seen || r_empty_seen);
    assign w_ins_at  = r_tomb_seen ? r_tomb_at : r_empty_at;

    always_comb begin
        tag_we    = i_cmd.clr || (i_cmd.act && (w_ins_new || (w_is_remove && r_hit)));
        tag_waddr = i_cmd.clr ? r_clr : (w_ins_new ? w_ins_at : r_hit_at);
        tag_wdata = i_cmd.clr ? TAG_EMPTY : (w_ins_new ? TAG_USED : TAG_TOMB);
        key_we    = i_cmd.act && w_ins_new;
        val_we    = i_cmd.act && (w_ins_new || ((w_is_insert || w_is_remove) && r_hit));
        val_waddr = w_ins_new ? w_ins_at : r_hit_at;
        val_wdata = w_is_remove ? '0 : r_val;
    end

    assign o_stat.clr_last  = (r_clr == {IDX_W{1'b1}});
    assign o_stat.hash_done = (r_hstep == HASH_STEPS);
    assign o_stat.probe_end = w_is_empty || w_is_hit || w_last;
    assign o_stat.out_free  = !r_ov || i_ready;

    // Control state: clearing sweep, counts, limit and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_used  <= '0;
            r_tomb  <= '0;
            r_limit <= LOAD_LIMIT_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.act && w_ins_new) begin
                r_used <= r_used + 1'b1;
                if (r_tomb_seen) begin
                    r_tomb <= r_tomb - 1'b1;
                end
            end else if (i_cmd.act && w_is_remove && r_hit) begin
                r_used <= r_used - 1'b1;
                r_tomb <= r_tomb + 1'b1;
            end
            if (i_cmd.resp) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_val   <= i_value;
            r_hash  <= i_key;
            r_hstep <= '0;
        end else if (i_cmd.hash_step) begin
            r_hash  <= wang_step(r_hash, r_hstep);
            r_hstep <= r_hstep + 1'b1;
        end

        if (i_cmd.probe_start) begin
            r_idx        <= r_hash[IDX_W-1:0];
            r_pcnt       <= '0;
            r_hit        <= 1'b0;
            r_tomb_seen  <= 1'b0;
            r_empty_seen <= 1'b0;
        end else if (i_cmd.eval) begin
            if (w_is_hit) begin
                r_hit     <= 1'b1;
                r_hit_at  <= r_idx;
                r_hit_val <= val_q;
            end
            if (w_is_empty) begin
                r_empty_seen <= 1'b1;
                r_empty_at   <= r_idx;
            end
            if (w_is_tomb && !r_tomb_seen) begin
                r_tomb_seen <= 1'b1;
                r_tomb_at   <= r_idx;
            end
            if (!o_stat.probe_end) begin
                r_idx  <= r_idx + 1'b1;
                r_pcnt <= r_pcnt + 1'b1;
            end
        end

        if (i_cmd.act) begin
            r_res_found  <= r_hit && (w_is_lookup || w_is_insert || w_is_remove);
            r_res_val    <= (w_is_lookup && r_hit) ? r_hit_val : '0;
            r_res_status <= w_is_insert && !r_hit && !w_ins_new;
            if (r_hit && (w_is_lookup || w_is_insert || w_is_remove)) begin
                r_res_slot <= SLOT_W'(r_hit_at);
            end else if (w_ins_new) begin
                r_res_slot <= SLOT_W'(w_ins_at);
            end else begin
                r_res_slot <= '0;
            end
        end

        if (i_cmd.resp) begin
            r_o_found  <= r_res_found;
            r_o_val    <= r_res_val;
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
        end
    end

    assign o_valid      = r_ov;
    assign o_found      = r_o_found;
    assign o_read_value = r_o_val;
    assign o_status     = r_o_status;
    assign o_slot_index = r_o_slot;

endmodule

[hw/rtl/lphm_checker.sv]
`include "assert_macros.svh"

module lphm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic                                o_found,
    input logic signed [lphm_pkg::WORD_W-1:0]  o_read_value,
    input logic                                o_status,
    input logic [lphm_pkg::SLOT_W-1:0]         o_slot_index
);

    // A stalled response keeps its slot and status.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_slot_index) && $stable(o_status), "stalled response changed")

    // A refused insert reports nothing else.
    `ASSERT_CLK(a_refused_clean, i_clk, i_rst_n, o_valid && o_status |-> !o_found && o_read_value == 0 && o_slot_index == 0, "refused insert with payload")

    // Without a hit there is no value to return.
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found |-> o_read_value == 0, "value on miss")

    // Requests are handled one at a time.
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second request taken at once")

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (.*);
